[rtl/mau_pkg.sv]
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, operation codes and sequencer types of the modular
// arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int KIND_W = 3;
  localparam int OPA_W  = 31;
  localparam int OPB_W  = 64;
  localparam int RES_W  = 31;
  localparam int MOD_W  = 31;
  localparam int CNT_W  = $clog2(OPB_W);

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_POW = 3'd4,
    KIND_NEG = 3'd5,
    KIND_INV = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_DISPATCH,
    S_NEGB,
    S_ADD,
    S_POW_TEST,
    S_MUL,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    ROLE_FINAL,
    ROLE_ACC,
    ROLE_SQ
  } mul_role_t;

endpackage

[rtl/mau_if.sv]
// ----------------------------------------------------------------------------
// mau_if
// Valid/ready channels of the modular arithmetic unit: operation request
// and result.
// ----------------------------------------------------------------------------
interface mau_in_if;
  import mau_pkg::*;

  logic             valid;
  logic             ready;
  logic [KIND_W-1:0] kind;
  logic [OPA_W-1:0]  operand_a;
  logic [OPB_W-1:0]  operand_b;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

interface mau_out_if;
  import mau_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

[rtl/modular_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Add, subtract, multiply, divide, power, negate and inverse modulo a
// configured modulus, built from bit-serial modular add/double steps.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries kind, operand_a and operand_b; one result per transaction
//   leaves on out_chan. The user must have cfg_wr_en/cfg_wr_data write the
//   modulus while idle (not enforced); only its low RESIDUE_WIDTH bits are used.
// Sequence:
//   every transaction first reduces both operands one bit a cycle.
//   negate ends at dispatch; add runs the add step and sub first negates b;
//   multiply runs a double step and an add step per multiplier bit;
//   power, inverse, divide: up to 64 rounds of one or two modular
//   multiplies, plus one multiply more for divide. The shared double-and-add
//   step sets the rate. A modulus of 0 or 1 gives 0 without these steps.
// Throughput: one transaction at a time; in_chan.ready is high while idle,
//   also while a finished result waits in the output register.
// Reset: the modulus returns to 1000000007, no result pending.
// Stall: a held result stays on out_chan; a newer one waits in the sequencer
//   until the output register frees.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
  parameter int RESIDUE_WIDTH = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mau_in_if.sink                     in_chan,
  mau_out_if.source                  out_chan,
  input  logic                       cfg_wr_en,
  input  logic [mau_pkg::MOD_W-1:0]  cfg_wr_data
);
  import mau_pkg::*;

  localparam int W = RESIDUE_WIDTH;

  function automatic logic [W-1:0] mod_add(input logic [W-1:0] p, input logic [W-1:0] q,
                                           input logic cin, input logic [W-1:0] mm);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, p} + {1'b0, q} + {{W{1'b0}}, cin};
    d = s - {1'b0, mm};
    return (s >= {1'b0, mm}) ? d[W-1:0] : s[W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  mul_role_t           role_r, role_nxt;
  logic [MOD_W-1:0]    modulus_r;
  logic [OPA_W-1:0]    a_sh_r, a_sh_nxt;
  logic [OPB_W-1:0]    b_sh_r, b_sh_nxt;
  logic [OPB_W-1:0]    exp_r, exp_nxt;
  logic [W-1:0]        ra_r, ra_nxt;
  logic [W-1:0]        rb_r, rb_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [W-1:0]        mx_r, mx_nxt;
  logic [W-1:0]        my_r, my_nxt;
  logic [W-1:0]        macc_r, macc_nxt;
  logic                half_r, half_nxt;
  logic [W-1:0]        base_r, base_nxt;
  logic [W-1:0]        pacc_r, pacc_nxt;
  logic [W-1:0]        wres_r, wres_nxt;
  logic [W-1:0]        out_res_r, out_res_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [OPB_W-1:0]    mod_ext;
  logic [W-1:0]        m;
  logic                m_le1;
  logic [W-1:0]        madd_p, madd_q, madd_out;
  logic                madd_cin;
  logic                a_bit;
  logic [W-1:0]        neg_in, neg_out;
  logic [W-1:0]        macc_new;
  logic                mul_go;
  logic [W-1:0]        mul_x, mul_y;
  mul_role_t           mul_role;
  logic [OPB_W-1:0]    res_ext;

  assign mod_ext = OPB_W'(modulus_r);
  assign m       = mod_ext[W-1:0];
  assign m_le1   = (m <= W'(1));

  assign in_chan.ready   = (state_r == S_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign res_ext         = OPB_W'(out_res_r);
  assign out_chan.result = res_ext[RES_W-1:0];

  assign a_bit   = (cnt_r <= CNT_W'(OPA_W - 1)) ? a_sh_r[OPA_W-1] : 1'b0;
  assign neg_in  = (state_r == S_NEGB) ? rb_r : ra_r;
  assign neg_out = (neg_in != '0) ? m - neg_in : '0;

  always_comb begin
    madd_p   = rb_r;
    madd_q   = rb_r;
    madd_cin = b_sh_r[OPB_W-1];
    case (state_r)
      S_ADD: begin
        madd_p   = ra_r;
        madd_q   = rb_r;
        madd_cin = 1'b0;
      end
      S_MUL: begin
        madd_p   = macc_r;
        madd_q   = half_r ? mx_r : macc_r;
        madd_cin = 1'b0;
      end
      default: begin
      end
    endcase
    madd_out = mod_add(madd_p, madd_q, madd_cin, m);
  end

  assign macc_new = my_r[W-1] ? madd_out : macc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MOD_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    role_r    <= role_nxt;
    a_sh_r    <= a_sh_nxt;
    b_sh_r    <= b_sh_nxt;
    exp_r     <= exp_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    cnt_r     <= cnt_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    macc_r    <= macc_nxt;
    half_r    <= half_nxt;
    base_r    <= base_nxt;
    pacc_r    <= pacc_nxt;
    wres_r    <= wres_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    role_nxt      = role_r;
    a_sh_nxt      = a_sh_r;
    b_sh_nxt      = b_sh_r;
    exp_nxt       = exp_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    cnt_nxt       = cnt_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    macc_nxt      = macc_r;
    half_nxt      = half_r;
    base_nxt      = base_r;
    pacc_nxt      = pacc_r;
    wres_nxt      = wres_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mul_go        = 1'b0;
    mul_x         = ra_r;
    mul_y         = rb_r;
    mul_role      = ROLE_FINAL;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt  = kind_t'(in_chan.kind);
          a_sh_nxt  = in_chan.operand_a;
          b_sh_nxt  = in_chan.operand_b;
          exp_nxt   = in_chan.operand_b;
          ra_nxt    = '0;
          rb_nxt    = '0;
          cnt_nxt   = CNT_W'(OPB_W - 1);
          state_nxt = S_REDUCE;
          if (m_le1) begin
            wres_nxt  = '0;
            state_nxt = S_FINISH;
          end
        end
      end
      S_REDUCE: begin
        ra_nxt   = mod_add(ra_r, ra_r, a_bit, m);
        rb_nxt   = madd_out;
        b_sh_nxt = b_sh_r << 1;
        if (cnt_r <= CNT_W'(OPA_W - 1)) begin
          a_sh_nxt = a_sh_r << 1;
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        pacc_nxt = W'(1);
        case (kind_r)
          KIND_ADD: begin
            state_nxt = S_ADD;
          end
          KIND_SUB: begin
            state_nxt = S_NEGB;
          end
          KIND_MUL: begin
            mul_go = 1'b1;
          end
          KIND_DIV: begin
            base_nxt  = rb_r;
            exp_nxt   = OPB_W'(m) - OPB_W'(2);
            state_nxt = S_POW_TEST;
            if (rb_r == '0) begin
              wres_nxt  = '0;
              state_nxt = S_FINISH;
            end
          end
          KIND_POW: begin
            base_nxt  = ra_r;
            state_nxt = S_POW_TEST;
          end
          KIND_NEG: begin
            wres_nxt  = neg_out;
            state_nxt = S_FINISH;
          end
          KIND_INV: begin
            base_nxt  = ra_r;
            exp_nxt   = OPB_W'(m) - OPB_W'(2);
            state_nxt = S_POW_TEST;
            if (ra_r == '0) begin
              wres_nxt  = '0;
              state_nxt = S_FINISH;
            end
          end
          default: begin
            wres_nxt  = '0;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_NEGB: begin
        rb_nxt    = neg_out;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        wres_nxt  = madd_out;
        state_nxt = S_FINISH;
      end
      S_POW_TEST: begin
        if (exp_r == '0) begin
          if (kind_r == KIND_DIV) begin
            mul_go = 1'b1;
            mul_x  = ra_r;
            mul_y  = pacc_r;
          end else begin
            wres_nxt  = pacc_r;
            state_nxt = S_FINISH;
          end
        end else if (exp_r[0]) begin
          mul_go   = 1'b1;
          mul_x    = base_r;
          mul_y    = pacc_r;
          mul_role = ROLE_ACC;
        end else begin
          mul_go   = 1'b1;
          mul_x    = base_r;
          mul_y    = base_r;
          mul_role = ROLE_SQ;
        end
      end
      S_MUL: begin
        if (!half_r) begin
          macc_nxt = madd_out;
          half_nxt = 1'b1;
        end else begin
          macc_nxt = macc_new;
          my_nxt   = my_r << 1;
          half_nxt = 1'b0;
          cnt_nxt  = cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            case (role_r)
              ROLE_ACC: begin
                pacc_nxt = macc_new;
                mul_go   = 1'b1;
                mul_x    = base_r;
                mul_y    = base_r;
                mul_role = ROLE_SQ;
              end
              ROLE_SQ: begin
                base_nxt  = macc_new;
                exp_nxt   = exp_r >> 1;
                state_nxt = S_POW_TEST;
              end
              default: begin
                wres_nxt  = macc_new;
                state_nxt = S_FINISH;
              end
            endcase
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_res_nxt   = wres_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (mul_go) begin
      mx_nxt    = mul_x;
      my_nxt    = mul_y;
      macc_nxt  = '0;
      half_nxt  = 1'b0;
      cnt_nxt   = CNT_W'(W - 1);
      role_nxt  = mul_role;
      state_nxt = S_MUL;
    end
  end

`ifndef ASSERT_OFF
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result became valid without a finished transaction");

  a_out_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !m_le1) |-> (out_res_r < m))
    else $error("result not below the modulus");

  a_reduce_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REDUCE) |-> (ra_r < m && rb_r < m))
    else $error("operand reduction left its range");

  a_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (macc_r < m && mx_r < m))
    else $error("multiply accumulator left its range");
`endif

endmodule

[tb/sv/modular_arithmetic_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_tb
// Self-checking bench for the modular arithmetic unit. Directed operations
// hit operand extremes, every kind, zero exponents, zero divisors and the
// unused kind code. Random operations then run over a series of moduli,
// including the largest, 0, 1, small primes and composites. Both channels
// idle and stall at random, with stretches of full rate. A scoreboard
// predicts each residue and compares it with the result channel.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_tb;
  import mau_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int MAX_IDLE         = 18;
  localparam int DRAIN_CYCLES     = 9000;
  localparam int NUM_PHASES       = 12;
  localparam int RANDOM_PER_PHASE = 160;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [OPA_W-1:0]  operand_a;
    logic [OPB_W-1:0]  operand_b;
  } mau_op_t;

  class residue_scoreboard;
    logic [RES_W-1:0] residue_q[$];
    int errors;
    int checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      return (x * y) % m;
    endfunction

    function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] ex;
      acc = 64'd1;
      if (m <= 64'd1) return 64'd0;
      if (e == 64'd0) return 64'd1;
      sq = base % m;
      ex = e;
      while (ex != 64'd0) begin
        if (ex[0]) acc = mul_mod(acc, sq, m);
        ex = ex >> 1;
        sq = mul_mod(sq, sq, m);
      end
      return acc;
    endfunction

    function logic [63:0] inv_mod(logic [63:0] x, logic [63:0] m);
      if (m <= 64'd1 || x == 64'd0) return 64'd0;
      return pow_mod(x, m - 64'd2, m);
    endfunction

    function logic [RES_W-1:0] expected_residue(mau_op_t op, logic [MOD_W-1:0] modv);
      logic [63:0] m;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] r;
      m = {33'd0, modv};
      if (m == 64'd0) m = 64'd1;
      a = {33'd0, op.operand_a} % m;
      b = op.operand_b % m;
      r = 64'd0;
      case (op.kind)
        KIND_ADD: begin
          r = a + b;
          if (r >= m) r = r - m;
        end
        KIND_SUB: r = (a >= b) ? a - b : a + (m - b);
        KIND_MUL: r = mul_mod(a, b, m);
        KIND_DIV: r = mul_mod(a, inv_mod(b, m), m);
        KIND_POW: r = pow_mod(a, op.operand_b, m);
        KIND_NEG: r = (a != 64'd0) ? m - a : 64'd0;
        KIND_INV: r = inv_mod(a, m);
        default:  r = 64'd0;
      endcase
      if (m == 64'd1) r = 64'd0;
      return r[RES_W-1:0];
    endfunction

    function void note_op(mau_op_t op, logic [MOD_W-1:0] modv);
      residue_q.push_back(expected_residue(op, modv));
    endfunction

    function void check_result(logic [RES_W-1:0] got);
      logic [RES_W-1:0] want;
      if (residue_q.size() == 0) begin
        $error("result: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = residue_q.pop_front();
      checked++;
      if (got !== want) begin
        $error("result: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return residue_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [MOD_W-1:0] cfg_wr_data;
  logic [MOD_W-1:0] cur_modulus;
  logic             sender_burst;
  logic             receiver_burst;
  int               sent_count;

  residue_scoreboard sb = new();

  mau_in_if  in_chan ();
  mau_out_if out_chan ();

  modular_arithmetic_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic [30:0] rand31();
    logic [31:0] w;
    w = $urandom;
    return w[30:0];
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OPA_W-1:0] pick_a(logic [MOD_W-1:0] m);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return m - 1'b1;
      3:       return m;
      default: return rand31();
    endcase
  endfunction

  function automatic logic [OPB_W-1:0] pick_b(logic [MOD_W-1:0] m);
    logic [63:0] mult;
    mult = {32'd0, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {33'd0, m} - 64'd1;
      3:       return {33'd0, m} * mult;
      4:       return 64'($urandom_range(0, 255));
      default: return rand64();
    endcase
  endfunction

  // mostly short exponents, a few full width
  function automatic logic [OPB_W-1:0] pick_exponent();
    int w;
    w = $urandom_range(1, 16);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 64'd1;
      2:       return '1;
      3:       return rand64();
      default: return rand64() >> (64 - w);
    endcase
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [OPA_W-1:0] a,
                         input logic [OPB_W-1:0] b);
    mau_op_t op;
    int gap;
    op.kind      = kind;
    op.operand_a = a;
    op.operand_b = b;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.kind      <= op.kind;
    in_chan.operand_a <= op.operand_a;
    in_chan.operand_b <= op.operand_b;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_op(op, cur_modulus);
    sent_count++;
  endtask

  task automatic random_op();
    int pick;
    logic [KIND_W-1:0] k;
    logic [OPA_W-1:0]  a;
    logic [OPB_W-1:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 20)      k = KIND_ADD;
    else if (pick < 40) k = KIND_SUB;
    else if (pick < 62) k = KIND_MUL;
    else if (pick < 78) k = KIND_NEG;
    else if (pick < 88) k = KIND_POW;
    else if (pick < 93) k = KIND_DIV;
    else                k = KIND_INV;
    a = pick_a(cur_modulus);
    b = (k == KIND_POW) ? pick_exponent() : pick_b(cur_modulus);
    send_op(k, a, b);
  endtask

  // sender holds off until every pending transaction has returned
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_modulus = value;
  endtask

  initial begin
    logic [MOD_W-1:0] phase_mod[NUM_PHASES];
    logic [MOD_W-1:0] mr;
    int p;
    int i;
    in_chan.valid     = 1'b0;
    in_chan.kind      = '0;
    in_chan.operand_a = '0;
    in_chan.operand_b = '0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    rst_n             = 1'b0;
    sender_burst      = 1'b0;
    sent_count        = 0;
    cur_modulus       = MOD_RESET;
    mr                = MOD_RESET;

    phase_mod[0]  = 31'd998244353;
    phase_mod[1]  = 31'h7FFFFFFF;
    phase_mod[2]  = 31'd1;
    phase_mod[3]  = 31'd0;
    phase_mod[4]  = 31'd2;
    phase_mod[5]  = 31'd3;
    phase_mod[6]  = 31'd251;
    phase_mod[7]  = 31'd1000000;
    phase_mod[8]  = 31'd65536;
    phase_mod[9]  = 31'($urandom_range(2, 32'h7FFFFFFF));
    phase_mod[10] = 31'($urandom_range(4, 5000));
    phase_mod[11] = MOD_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed operations at the reset modulus
    send_op(KIND_ADD, '1, '1);
    send_op(KIND_ADD, mr - 1'b1, 64'd1);
    send_op(KIND_ADD, '0, '0);
    send_op(KIND_SUB, '0, 64'd1);
    send_op(KIND_SUB, '1, '0);
    send_op(KIND_SUB, 31'd5, {33'd0, mr});
    send_op(KIND_MUL, '1, '1);
    send_op(KIND_MUL, 31'd12345, '0);
    send_op(KIND_DIV, 31'd10, '0);
    send_op(KIND_DIV, '1, 64'd2);
    send_op(KIND_DIV, 31'd1, '1);
    send_op(KIND_POW, '0, '0);
    send_op(KIND_POW, 31'd5, '0);
    send_op(KIND_POW, 31'd2, '1);
    send_op(KIND_POW, '1, 64'd1);
    send_op(KIND_POW, mr, 64'd5);
    send_op(KIND_POW, 31'd3, 64'h8000_0000_0000_0000);
    send_op(KIND_NEG, '0, rand64());
    send_op(KIND_NEG, '1, '0);
    send_op(KIND_NEG, mr, '1);
    send_op(KIND_INV, '0, '0);
    send_op(KIND_INV, 31'd1, '0);
    send_op(KIND_INV, '1, '1);
    send_op(KIND_INV, mr + 1'b1, '0);
    send_op(KIND_UNUSED, '1, '1);
    drain_results();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_modulus(phase_mod[p]);
      sender_burst = (p % 3 == 1);
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        random_op();
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("modular_arithmetic_unit_tb: %0d operations over %0d modulus settings",
             sent_count, NUM_PHASES + 1);
    $display("modular_arithmetic_unit_tb: %0d results checked, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("modular_arithmetic_unit_tb: done, clean");
    end else begin
      $display("modular_arithmetic_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    int stall;
    int taken;
    out_chan.ready = 1'b0;
    receiver_burst = 1'b0;
    taken          = 0;
    @(posedge rst_n);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clk);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      sb.check_result(out_chan.result);
      taken++;
      if (taken % 64 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #(600_000_000);
    $display("modular_arithmetic_unit_tb: done, errors");
    $finish;
  end

endmodule
